### design/sorted_list_insert_remove_core_defines.svh
// Assertion macros shared by the sorted list checker.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on aclk, held off during reset.
`define SLI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, held off during reset.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sli_pkg.sv
// Shared types and codes for the sorted list insert/remove core.
package sli_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic                       ins_en;  // accepted insert, list not full
        logic                       rem_en;  // accepted remove, match exists
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

endpackage

### design/sli_cell.sv
// One storage cell of the sorted list shift chain.
module sli_cell
    import sli_pkg::*;
(
    input  logic                       aclk,
    input  cmd_t                       cmd,
    input  logic                       occ,         // this cell holds a live entry
    input  logic                       left_gt,     // left neighbor live and > value
    input  logic signed [VALUE_W-1:0]  left_entry,
    input  logic signed [VALUE_W-1:0]  right_entry,
    output logic signed [VALUE_W-1:0]  entry,
    output logic                       gt,
    output logic                       match
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      ge;

    assign gt    = occ && (entry_reg > cmd.value);
    assign ge    = occ && (entry_reg >= cmd.value);
    assign match = occ && (entry_reg == cmd.value);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins_en) begin
            // shift up behind the insertion point, drop value at the point
            if (left_gt) begin
                entry_next = left_entry;
            end else if (gt || !occ) begin
                entry_next = cmd.value;
            end
        end else if (cmd.rem_en) begin
            // list is sorted, so first entry >= value is the first match
            if (ge) begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

### design/sorted_list_insert_remove_core.sv
// Top level of the sorted list insert/remove core: cell chain, count and result register.
//
//  Channel | Ports                          | Direction | Carries
//  --------+--------------------------------+-----------+------------------------------
//  s_      | s_valid s_ready s_mode s_value | in        | insert/remove request
//  m_      | m_valid m_ready m_count m_status | out     | new count and status
//
// One request per cycle while s_ready is high: every cell compares against the
// request value in parallel and shifts in the same cycle, so the chain takes
// one request each clock; the result is registered in the cycle after acceptance.
// The output register frees as it is taken, so s_ready stays high while
// m_ready is high. aresetn (sync, active low) clears the count and the
// result valid; entry contents are left alone and are never read unwritten.
module sorted_list_insert_remove_core
    import sli_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [COUNT_W-1:0]         m_count,
    output logic [STATUS_W-1:0]        m_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    status_t           status_reg;
    status_t           status_next;

    logic              accept;
    logic              full;
    logic              found;
    cmd_t              cmd;

    // chain wiring between cells
    logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]       cell_gt;
    logic [CAPACITY-1:0]       cell_match;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    // equal entries sit together, so any live match means the remove hits
    assign found   = |cell_match;

    assign cmd.ins_en = accept && (s_mode == MODE_INSERT) && !full;
    assign cmd.rem_en = accept && (s_mode == MODE_REMOVE) && found;
    assign cmd.value  = s_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      occ;
        logic                      lgt;
        logic signed [VALUE_W-1:0] lent;
        logic signed [VALUE_W-1:0] rent;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign lgt  = 1'b0;
            assign lent = s_value;
        end else begin : g_mid
            assign lgt  = cell_gt[i-1];
            assign lent = cell_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign rent = cell_entry[i];
        end else begin : g_notlast
            assign rent = cell_entry[i+1];
        end

        sli_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occ         (occ),
            .left_gt     (lgt),
            .left_entry  (lent),
            .right_entry (rent),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i]),
            .match       (cell_match[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            unique case (s_mode)
                MODE_INSERT: begin
                    status_next = full ? ST_FULL : ST_OK;
                end
                MODE_REMOVE: begin
                    status_next = found ? ST_OK : ST_MISSING;
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
        if (cmd.ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.rem_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset needed
    logic [COUNT_W-1:0] rcount_reg;

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (accept) begin
            rcount_reg <= COUNT_W'(count_next);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_count  = rcount_reg;
    assign m_status = status_reg;

endmodule

### design/sli_checker.sv
// Port-level checker for the sorted list core, bound to the top level.
`include "sorted_list_insert_remove_core_defines.svh"

module sli_checker
    import sli_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [COUNT_W-1:0]         m_count,
    input logic [STATUS_W-1:0]        m_status
);

    logic in_fire;
    assign in_fire = s_valid && s_ready;

    `SLI_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_count) && $stable(m_status), "result changed while stalled")
    `SLI_ASSERT_NOW(a_status_legal, m_valid, m_status == ST_OK || m_status == ST_FULL || m_status == ST_MISSING, "illegal status code")
    `SLI_ASSERT_NOW(a_full_count, m_valid && m_status == ST_FULL, m_count == COUNT_W'(CAPACITY), "full status with short count")
    `SLI_ASSERT_NEXT(a_request_answered, in_fire, m_valid, "accepted request gave no result")

endmodule

bind sorted_list_insert_remove_core sli_checker #(.CAPACITY(CAPACITY)) u_sli_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_count  (m_count),
    .m_status (m_status)
);
